FILE: hw/rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the RSSI distance estimator
// Field widths, register codes, fixed-point constants and the structs that
// travel between the front end, the back end and the divider.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int WINDOW_DEPTH_DEF = 5;

  localparam int RSSI_W     = 13;
  localparam int SNR_W      = 10;
  localparam int LOSS_W     = 12;
  localparam int DIST_W     = 32;
  localparam int EXP_W      = 6;
  localparam int WGT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int S_TDATA_W = 24;  // rssi, snr, zero pad
  localparam int M_TDATA_W = 56;  // distance, median_loss, smoothed_loss_out
  localparam int M_TUSER_W = 2;   // outlier_replaced, valid_res

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_LOSS = 2'd0,
    CFG_EXPONENT = 2'd1,
    CFG_WEIGHT   = 2'd2
  } cfg_idx_e;

  localparam logic [LOSS_W-1:0] REF_RESET = 12'd1440;
  localparam logic [EXP_W-1:0]  EXP_RESET = 6'd23;
  localparam logic [WGT_W-1:0]  WGT_RESET = 9'd128;
  localparam logic [WGT_W-1:0]  WGT_FULL  = 9'd256;

  localparam logic signed [SNR_W-1:0] SNR_REPLACE_MIN = 10'sd40;

  localparam logic [29:0] LOG2_10_Q28 = 30'd891723283;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam int          FRAC_W      = 28;
  localparam int          K_W         = 12;
  localparam int          EXP_BIAS    = 22;   // 30 fraction bits less 8 output bits
  localparam int          TERMS       = 14;

  localparam int DIV_NUM_W     = 44;
  localparam int DIV_DEN_W     = 10;
  localparam int DIV_STEP_BITS = 4;

  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    logic              store;
    logic              test;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: hw/rtl/rde_front.sv
// ----------------------------------------------------------------------------
// rde_front: input beat classification and item queue
// Turns each input beat into a clamped path loss plus store and outlier-test
// flags, and holds the items in a short queue for the back end.
// ----------------------------------------------------------------------------
module rde_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [12:0] rssi, [22:13] snr, [23] zero
  input  logic [rde_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                           item_valid_o,
  output rde_pkg::item_t                 item_o,
  input  logic                           item_pop_i
);
  import rde_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);

  logic signed [RSSI_W-1:0] rssi;
  logic signed [SNR_W-1:0]  snr;
  logic signed [RSSI_W:0]   neg_rssi;
  item_t                    item_in;

  item_t            mem_q [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPW:0]     cnt_q;
  logic             push, pop;

  always_comb begin
    rssi     = s_axis_tdata[RSSI_W-1:0];
    snr      = s_axis_tdata[RSSI_W +: SNR_W];
    neg_rssi = -$signed({rssi[RSSI_W-1], rssi});
    // Negative loss clamps to zero; the single value above the range saturates.
    priority if (neg_rssi[RSSI_W]) begin
      item_in.loss = '0;
    end else if (neg_rssi[LOSS_W]) begin
      item_in.loss = '1;
    end else begin
      item_in.loss = neg_rssi[LOSS_W-1:0];
    end
    item_in.store = !snr[SNR_W-1];
    item_in.test  = (snr >= SNR_REPLACE_MIN);
  end

  assign s_axis_tready = (cnt_q != (QPW+1)'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != '0);
  assign pop           = item_pop_i && item_valid_o;
  assign item_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: hw/rtl/rde_div.sv
// ----------------------------------------------------------------------------
// rde_div: iterative unsigned divider
// Restoring division that retires DIV_STEP_BITS quotient bits per cycle; shared by
// the log-ratio scaling and the series terms of the exponential.
// ----------------------------------------------------------------------------
module rde_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rde_pkg::div_req_t req_i,
  output rde_pkg::div_rsp_t rsp_o
);
  import rde_pkg::*;

  localparam int ITER = DIV_NUM_W / DIV_STEP_BITS;
  localparam int CW   = $clog2(ITER + 1);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_NUM_W-1:0] quot_q, quot_n;
  logic [DIV_DEN_W-1:0] rem_q, rem_n, den_q;
  logic [DIV_DEN_W:0]   part;

  always_comb begin
    rem_n  = rem_q;
    quot_n = quot_q;
    part   = '0;
    for (int s = 0; s < DIV_STEP_BITS; s++) begin
      part   = {rem_n, quot_n[DIV_NUM_W-1]};
      quot_n = {quot_n[DIV_NUM_W-2:0], 1'b0};
      if (part >= {1'b0, den_q}) begin
        rem_n     = DIV_DEN_W'(part - {1'b0, den_q});
        quot_n[0] = 1'b1;
      end else begin
        rem_n = part[DIV_DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      quot_q <= quot_n;
      rem_q  <= rem_n;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: hw/rtl/rde_back.sv
// ----------------------------------------------------------------------------
// rde_back: window filter, smoothing and distance sequencer
// Keeps the loss window, finds the median and window moments over cycles,
// runs the outlier test and the moving average, then evaluates the
// log-distance model with the shared divider and registers the result beat.
// ----------------------------------------------------------------------------
module rde_back #(
  parameter int WINDOW_DEPTH = rde_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            item_valid_i,
  input  rde_pkg::item_t                  item_i,
  output logic                            item_pop_o,
  output rde_pkg::div_req_t               div_req_o,
  input  rde_pkg::div_rsp_t               div_rsp_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] distance, [43:32] median_loss, [55:44] smoothed_loss_out
  output logic [rde_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] outlier_replaced, [1] valid_res
  output logic [rde_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import rde_pkg::*;

  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int SW = LOSS_W + FW;
  localparam int QW = 2 * LOSS_W + FW;
  localparam int PW = 2 * SW;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_SCAN = 15'b000000000000010,
    S_DEV  = 15'b000000000000100,
    S_DSQ  = 15'b000000000001000,
    S_NQ   = 15'b000000000010000,
    S_SS   = 15'b000000000100000,
    S_TEST = 15'b000000001000000,
    S_EMA1 = 15'b000000010000000,
    S_EMA2 = 15'b000000100000000,
    S_MAG  = 15'b000001000000000,
    S_YDIV = 15'b000010000000000,
    S_TMUL = 15'b000100000000000,
    S_TERM = 15'b001000000000000,
    S_TDIV = 15'b010000000000000,
    S_FIN  = 15'b100000000000000
  } state_e;

  state_e state_q;

  logic [LOSS_W-1:0] win_q [WINDOW_DEPTH];
  logic [IW-1:0]     wpos_q, idx_q, rep_idx, wpos_nxt;
  logic [FW-1:0]     fill_q;
  logic [LOSS_W-1:0] ema_q, ref_q;
  logic [EXP_W-1:0]  exp_q;
  logic [WGT_W-1:0]  wgt_q;

  logic [LOSS_W-1:0] loss_q, med_q;
  logic              test_q, repl_q, empty_q;
  logic [SW-1:0]     sum_q;
  logic [QW-1:0]     sq_q;
  logic signed [SW:0] dev_q;
  logic [PW-1:0]     dsq_q, nq_q, ss_q;
  logic [20:0]       ep1_q;
  logic              neg_q;
  logic signed [K_W-1:0] k_q;
  logic [FRAC_W-1:0] f_q;
  logic [29:0]       t_q;
  logic [30:0]       term_q;
  logic [31:0]       acc_q;
  logic [3:0]        n_q;

  logic                 out_valid_q, out_repl_q, out_vres_q;
  logic [DIST_W-1:0]    out_dist_q;
  logic [LOSS_W-1:0]    out_med_q, out_ema_q;

  // Scan, moments and test
  logic [LOSS_W-1:0] cur;
  logic [FW-1:0]     lt_cnt, le_cnt, mhalf;
  logic              hit, last;
  logic [SW-1:0]     nl, dev_mag;
  logic signed [SW:0] dev_nxt;
  logic [PW-1:0]     diff;
  // Smoothing
  logic [WGT_W-1:0]  w_eff;
  logic [20:0]       ep2;
  logic [21:0]       ema_sum;
  // Distance
  logic signed [LOSS_W:0] dist_d;
  logic [LOSS_W-1:0]  mag;
  logic [EXP_W-1:0]   pl;
  logic [DIV_NUM_W-1:0] num_mag;
  logic [57:0]        fl;
  logic [60:0]        tp;
  logic [K_W-1:0]     kpos;
  logic [FRAC_W-1:0]  f_raw;
  logic signed [K_W-1:0] sft, sh;
  logic [32:0]        rnd;
  logic [DIST_W-1:0]  dist_res;
  logic               out_free;

  always_comb begin
    cur    = win_q[idx_q];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      if (FW'(j) < fill_q) begin
        lt_cnt = lt_cnt + FW'(win_q[j] < cur);
        le_cnt = le_cnt + FW'(win_q[j] <= cur);
      end
    end
    mhalf = fill_q >> 1;
    // The entry is the upper median when its rank range covers fill/2.
    hit   = (lt_cnt <= mhalf) && (mhalf < le_cnt);
    last  = (FW'(idx_q) == fill_q - 1'b1);

    nl      = SW'(fill_q) * SW'(loss_q);
    dev_nxt = $signed({1'b0, nl}) - $signed({1'b0, sum_q});
    dev_mag = dev_q[SW] ? SW'(-dev_q) : dev_q[SW-1:0];
    diff    = nq_q - ss_q;
    rep_idx = (wpos_q == '0) ? IW'(WINDOW_DEPTH - 1) : wpos_q - 1'b1;
    wpos_nxt = (wpos_q == IW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + 1'b1;

    w_eff   = (wgt_q > WGT_FULL) ? WGT_FULL : wgt_q;
    ep2     = 21'(WGT_FULL - w_eff) * 21'(ema_q);
    ema_sum = 22'(ep1_q) + 22'(ep2) + 22'd128;

    dist_d  = $signed({1'b0, ema_q}) - $signed({1'b0, ref_q});
    mag     = dist_d[LOSS_W] ? LOSS_W'(-dist_d) : dist_d[LOSS_W-1:0];
    pl      = (exp_q == '0) ? EXP_W'(1) : exp_q;
    num_mag = DIV_NUM_W'(mag) * DIV_NUM_W'(LOG2_10_Q28) + DIV_NUM_W'({pl, 3'b000});
    fl      = 58'(f_q) * 58'(LN2_Q30);
    tp      = 61'(term_q) * 61'(t_q);

    kpos    = K_W'(div_rsp_i.quot[DIV_NUM_W-1:FRAC_W]);
    f_raw   = div_rsp_i.quot[FRAC_W-1:0];

    sft = k_q - K_W'(EXP_BIAS);
    sh  = -sft;
    rnd = '0;
    priority if (sft >= K_W'(2)) begin
      dist_res = '1;
    end else if (sft == K_W'(1)) begin
      dist_res = {acc_q[30:0], 1'b0};
    end else if (sft == '0) begin
      dist_res = acc_q;
    end else if (sh > K_W'(31)) begin
      dist_res = '0;
    end else begin
      rnd      = (33'(acc_q) + (33'd1 << (sh[4:0] - 5'd1))) >> sh[4:0];
      dist_res = rnd[DIST_W-1:0];
    end

    out_free = !out_valid_q || m_axis_tready;
  end

  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;

  always_comb begin
    div_req_o.start = (state_q == S_MAG) || (state_q == S_TERM);
    if (state_q == S_MAG) begin
      div_req_o.num = num_mag;
      div_req_o.den = {pl, 4'b0000};
    end else begin
      div_req_o.num = DIV_NUM_W'(tp[60:30]);
      div_req_o.den = DIV_DEN_W'(n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      wpos_q      <= '0;
      fill_q      <= '0;
      ema_q       <= REF_RESET;
      ref_q       <= REF_RESET;
      exp_q       <= EXP_RESET;
      wgt_q       <= WGT_RESET;
      out_valid_q <= 1'b0;
      empty_q     <= 1'b0;
      repl_q      <= 1'b0;
    end else begin
      // A beat loaded in the finish state overrides the drain of the old one.
      if (out_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_REF_LOSS: begin
            ref_q  <= cfg_data_i[LOSS_W-1:0];
            ema_q  <= cfg_data_i[LOSS_W-1:0];
            wpos_q <= '0;
            fill_q <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
              win_q[i] <= '0;
            end
          end
          CFG_EXPONENT: exp_q <= cfg_data_i[EXP_W-1:0];
          CFG_WEIGHT:   wgt_q <= cfg_data_i[WGT_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            loss_q <= item_i.loss;
            test_q <= item_i.test;
            idx_q  <= '0;
            sum_q  <= '0;
            sq_q   <= '0;
            if (item_i.store) begin
              win_q[wpos_q] <= item_i.loss;
              wpos_q        <= wpos_nxt;
              if (fill_q != FW'(WINDOW_DEPTH)) begin
                fill_q <= fill_q + 1'b1;
              end
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (fill_q == '0) begin
            empty_q <= 1'b1;
            state_q <= S_FIN;
          end else begin
            sum_q <= sum_q + SW'(cur);
            sq_q  <= sq_q + QW'(cur) * QW'(cur);
            if (hit) begin
              med_q <= cur;
            end
            idx_q <= idx_q + 1'b1;
            if (last) begin
              state_q <= S_DEV;
            end
          end
        end
        S_DEV: begin
          dev_q   <= dev_nxt;
          state_q <= S_DSQ;
        end
        S_DSQ: begin
          dsq_q   <= PW'(dev_mag) * PW'(dev_mag);
          state_q <= S_NQ;
        end
        S_NQ: begin
          nq_q    <= PW'(fill_q) * PW'(sq_q);
          state_q <= S_SS;
        end
        S_SS: begin
          ss_q    <= PW'(sum_q) * PW'(sum_q);
          state_q <= S_TEST;
        end
        S_TEST: begin
          // Newest sample more than two deviations off the mean.
          if (test_q && ({2'b00, dsq_q} > {diff, 2'b00})) begin
            win_q[rep_idx] <= med_q;
            repl_q         <= 1'b1;
          end
          state_q <= S_EMA1;
        end
        S_EMA1: begin
          ep1_q   <= 21'(w_eff) * 21'(med_q);
          state_q <= S_EMA2;
        end
        S_EMA2: begin
          ema_q   <= ema_sum[19:8];
          state_q <= S_MAG;
        end
        S_MAG: begin
          neg_q   <= dist_d[LOSS_W];
          state_q <= S_YDIV;
        end
        S_YDIV: begin
          if (div_rsp_i.done) begin
            if (neg_q) begin
              k_q <= -$signed(kpos) - $signed(K_W'(f_raw != '0));
              f_q <= -f_raw;
            end else begin
              k_q <= $signed(kpos);
              f_q <= f_raw;
            end
            state_q <= S_TMUL;
          end
        end
        S_TMUL: begin
          t_q     <= fl[57:28];
          term_q  <= 31'h4000_0000;
          acc_q   <= 32'h4000_0000;
          n_q     <= 4'd1;
          state_q <= S_TERM;
        end
        S_TERM: begin
          state_q <= S_TDIV;
        end
        S_TDIV: begin
          if (div_rsp_i.done) begin
            term_q <= div_rsp_i.quot[30:0];
            acc_q  <= acc_q + 32'(div_rsp_i.quot[30:0]);
            if (n_q == 4'(TERMS)) begin
              state_q <= S_FIN;
            end else begin
              n_q     <= n_q + 1'b1;
              state_q <= S_TERM;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_vres_q  <= !empty_q;
            out_repl_q  <= repl_q && !empty_q;
            out_dist_q  <= empty_q ? '0 : dist_res;
            out_med_q   <= empty_q ? '0 : med_q;
            out_ema_q   <= empty_q ? '0 : ema_q;
            empty_q     <= 1'b0;
            repl_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ema_q, out_med_q, out_dist_q};
  assign m_axis_tuser  = {out_vres_q, out_repl_q};

endmodule

FILE: hw/rtl/rssi_distance_estimator.sv
// ----------------------------------------------------------------------------
// rssi_distance_estimator: path-loss ranging from packet RSSI
// Median window filter, outlier replacement, moving average and
// log-distance model per received packet.
// ----------------------------------------------------------------------------
// Per item the median scan visits each filled window entry in turn, then
// the divider makes 15 passes: one for the log ratio, one per series term.
// Throughput: one item at a time in the back end; the two-entry input queue
// and the output register let both sides run on. An empty window goes from
// the scan state straight to the finish state. Reset clears queue, window and
// sequencer and loads the register reset values; no clearing pass is needed.
module rssi_distance_estimator #(
  parameter int WINDOW_DEPTH = rde_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [12:0] rssi, [22:13] snr, [23] zero
  input  logic [rde_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] distance, [43:32] median_loss, [55:44] smoothed_loss_out
  output logic [rde_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] outlier_replaced, [1] valid_res
  output logic [rde_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import rde_pkg::*;

  logic     item_valid, item_pop;
  item_t    item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  rde_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  rde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rde_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: hw/rtl/rde_checker.sv
// ----------------------------------------------------------------------------
// rde_checker: port-level checks of the RSSI distance estimator
// Tracks beats in flight and checks the result beats against them.
// ----------------------------------------------------------------------------
module rde_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rde_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [rde_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import rde_pkg::*;

  logic [2:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result beat without an accepted input beat");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more beats in flight than queue and stages hold");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("empty-window result carries data");

endmodule

bind rssi_distance_estimator rde_checker u_rde_checker (.*);
